// File: hdl/euler_angle_vector_rotation_top_macros.svh
// assertion macros for the euler angle vector rotation block
`ifndef EULER_ANGLE_VECTOR_ROTATION_TOP_MACROS_SVH
`define EULER_ANGLE_VECTOR_ROTATION_TOP_MACROS_SVH
`ifndef SYNTH
`define EAVR_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define EAVR_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define EAVR_ASSERT_IMP(label, clk, rst_n, a, b)
`define EAVR_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hdl/eavr_pkg.sv
// ----------------------------------------------------------------------------
// eavr_pkg
// Types, constants and arithmetic helpers of the euler angle vector rotation.
// ----------------------------------------------------------------------------
package eavr_pkg;

	localparam int CordicSteps = 18;
	// prep stage, cordic cells, four matrix stages, product stage, output stage
	localparam int Stages = CordicSteps + 7;

	localparam int IdxRoll  = 0;
	localparam int IdxPitch = 1;
	localparam int IdxYaw   = 2;

	localparam logic signed [32:0] CordicK = 33'sd652032874;
	localparam logic signed [23:0] HalfPi  = 24'sd1647099;
	localparam logic signed [23:0] Pi      = 24'sd3294199;

	typedef logic signed [31:0] q30_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [31:0] vec_x_in;
		logic signed [31:0] vec_y_in;
		logic signed [31:0] vec_z_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] vec_x_out;
		logic signed [31:0] vec_y_out;
		logic signed [31:0] vec_z_out;
	} rsp_t;

	typedef struct packed {
		logic [2:0][32:0] x;
		logic [2:0][32:0] y;
		logic [2:0][23:0] z;
		logic [2:0]       flip;
		logic [2:0][31:0] vec;
	} cordic_t;

	typedef struct packed {
		logic [2:0][2:0][31:0] r;
		logic [2:0][31:0]      vec;
	} mat_t;

	function automatic logic signed [23:0] atan_q20(input int step);
		case (step)
			0: atan_q20 = 24'sd823550;
			1: atan_q20 = 24'sd486170;
			2: atan_q20 = 24'sd256879;
			3: atan_q20 = 24'sd130396;
			4: atan_q20 = 24'sd65451;
			5: atan_q20 = 24'sd32757;
			6: atan_q20 = 24'sd16383;
			7: atan_q20 = 24'sd8192;
			8: atan_q20 = 24'sd4096;
			9: atan_q20 = 24'sd2048;
			10: atan_q20 = 24'sd1024;
			11: atan_q20 = 24'sd512;
			12: atan_q20 = 24'sd256;
			13: atan_q20 = 24'sd128;
			14: atan_q20 = 24'sd64;
			15: atan_q20 = 24'sd32;
			16: atan_q20 = 24'sd16;
			17: atan_q20 = 24'sd8;
			default: atan_q20 = 24'sd0;
		endcase
	endfunction

	function automatic q30_t clamp_q30(input logic signed [33:0] v);
		if (v > 34'sd1073741824) begin
			clamp_q30 = 32'sd1073741824;
		end else if (v < -34'sd1073741824) begin
			clamp_q30 = -32'sd1073741824;
		end else begin
			clamp_q30 = q30_t'(v);
		end
	endfunction

	// product of two q30 values, rounded half up
	function automatic q30_t mulq(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + 64'sd536870912;
		mulq = q30_t'(p >>> 30);
	endfunction

	function automatic logic signed [31:0] sat_out(input logic signed [63:0] acc);
		logic signed [63:0] r;
		r = (acc + 64'sd536870912) >>> 30;
		if (r > 64'sd2147483647) begin
			sat_out = 32'sh7fffffff;
		end else if (r < -64'sd2147483648) begin
			sat_out = 32'sh80000000;
		end else begin
			sat_out = r[31:0];
		end
	endfunction

endpackage

// File: hdl/euler_angle_vector_rotation_top.sv
// ----------------------------------------------------------------------------
// euler_angle_vector_rotation_top
// Inertial to body frame rotation of a vector by roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_stall is low and returns one beat per input,
// in order, through one fold stage, a chain of 18 cordic cells giving the sines
// and cosines of all three angles at once, four matrix stages, one stage of
// matrix-vector products and the rounding and saturating output register.
// Each stage holds while the one after it is full and stalled, so bubbles are
// squeezed out before req_stall rises.
`include "euler_angle_vector_rotation_top_macros.svh"

module euler_angle_vector_rotation_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  eavr_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output eavr_pkg::rsp_t rsp_data
);

	localparam int N    = eavr_pkg::Stages;
	localparam int NCel = eavr_pkg::CordicSteps;

	logic [N-1:0] vld_q;
	logic [N-1:0] en;

	eavr_pkg::cordic_t prep;
	eavr_pkg::cordic_t chain [0:NCel];
	eavr_pkg::mat_t    mat;
	logic [2:0][2:0][63:0] prod_s23;
	eavr_pkg::rsp_t    out_s24;

	always_comb begin
		en[N-1] = !vld_q[N-1] || !rsp_stall;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign req_stall = !en[0];
	assign rsp_valid = vld_q[N-1];
	assign rsp_data  = out_s24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// angle to q20 and fold into the cordic range
	always_comb begin
		logic [2:0][15:0] ang;
		logic signed [23:0] z;
		ang[eavr_pkg::IdxRoll]  = req_data.roll;
		ang[eavr_pkg::IdxPitch] = req_data.pitch;
		ang[eavr_pkg::IdxYaw]   = req_data.yaw;
		for (int l = 0; l < 3; l++) begin
			z = {ang[l][15], ang[l], 7'b0};
			prep.x[l]    = eavr_pkg::CordicK;
			prep.y[l]    = '0;
			prep.flip[l] = 1'b0;
			prep.z[l]    = z;
			if (z > eavr_pkg::HalfPi) begin
				prep.z[l]    = z - eavr_pkg::Pi;
				prep.flip[l] = 1'b1;
			end else if (z < -eavr_pkg::HalfPi) begin
				prep.z[l]    = z + eavr_pkg::Pi;
				prep.flip[l] = 1'b1;
			end
		end
		prep.vec[0] = req_data.vec_x_in;
		prep.vec[1] = req_data.vec_y_in;
		prep.vec[2] = req_data.vec_z_in;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			chain[0] <= prep;
		end
	end

	for (genvar i = 0; i < NCel; i++) begin : g_cell
		eavr_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk(clk),
			.en (en[i+1]),
			.d  (chain[i]),
			.q  (chain[i+1])
		);
	end

	eavr_matrix u_matrix (
		.clk(clk),
		.en (en[NCel+4:NCel+1]),
		.d  (chain[NCel]),
		.q  (mat)
	);

	always_ff @(posedge clk) begin
		if (en[N-2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s23[i][j] <= 64'($signed(mat.r[i][j])) * 64'($signed(mat.vec[j]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			out_s24.vec_x_out <= eavr_pkg::sat_out($signed(prod_s23[0][0])
				+ $signed(prod_s23[0][1]) + $signed(prod_s23[0][2]));
			out_s24.vec_y_out <= eavr_pkg::sat_out($signed(prod_s23[1][0])
				+ $signed(prod_s23[1][1]) + $signed(prod_s23[1][2]));
			out_s24.vec_z_out <= eavr_pkg::sat_out($signed(prod_s23[2][0])
				+ $signed(prod_s23[2][1]) + $signed(prod_s23[2][2]));
		end
	end

	`EAVR_ASSERT_IMP(a_stall_cause, clk, arst_n, req_stall, rsp_valid && rsp_stall)
	`EAVR_ASSERT_NXT(a_accept_enters, clk, arst_n, req_valid && !req_stall, vld_q[0])
	`EAVR_ASSERT_NXT(a_first_holds, clk, arst_n, vld_q[0] && !en[0], vld_q[0])

endmodule

// File: hdl/eavr_cordic_cell.sv
// ----------------------------------------------------------------------------
// eavr_cordic_cell
// One rotation-mode cordic iteration for the three angle lanes, registered.
// ----------------------------------------------------------------------------
module eavr_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  eavr_pkg::cordic_t d,
	output eavr_pkg::cordic_t q
);

	eavr_pkg::cordic_t nxt;

	always_comb begin
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [23:0] z;
		nxt = d;
		for (int l = 0; l < 3; l++) begin
			x = $signed(d.x[l]);
			y = $signed(d.y[l]);
			z = $signed(d.z[l]);
			if (z >= 24'sd0) begin
				nxt.x[l] = x - (y >>> STEP);
				nxt.y[l] = y + (x >>> STEP);
				nxt.z[l] = z - eavr_pkg::atan_q20(STEP);
			end else begin
				nxt.x[l] = x + (y >>> STEP);
				nxt.y[l] = y - (x >>> STEP);
				nxt.z[l] = z + eavr_pkg::atan_q20(STEP);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// File: hdl/eavr_matrix.sv
// ----------------------------------------------------------------------------
// eavr_matrix
// Sine/cosine clean-up and the four-stage build of the rotation matrix.
// ----------------------------------------------------------------------------
module eavr_matrix (
	input  logic              clk,
	input  logic [3:0]        en,
	input  eavr_pkg::cordic_t d,
	output eavr_pkg::mat_t    q
);

	localparam int R = eavr_pkg::IdxRoll;
	localparam int P = eavr_pkg::IdxPitch;
	localparam int Y = eavr_pkg::IdxYaw;

	logic [2:0][31:0] sin_s1, cos_s1, vec_s1;
	logic [31:0] cpsi_cth_s2, cth_spsi_s2, cpsi_sphi_s2, cphi_spsi_s2;
	logic [31:0] cphi_cpsi_s2, sphi_spsi_s2, cth_sphi_s2, cth_cphi_s2, sth_s2;
	logic [2:0][31:0] vec_s2;
	logic [31:0] cpsi_cth_s3, cth_spsi_s3, cpsi_sphi_s3, cphi_spsi_s3;
	logic [31:0] cphi_cpsi_s3, sphi_spsi_s3, cth_sphi_s3, cth_cphi_s3, sth_s3;
	logic [31:0] t10_s3, t11_s3, t20_s3, t21_s3;
	logic [2:0][31:0] vec_s3;

	// undo the half-turn fold and clamp to unit range
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < 3; l++) begin
				if (d.flip[l]) begin
					cos_s1[l] <= eavr_pkg::clamp_q30(-34'($signed(d.x[l])));
					sin_s1[l] <= eavr_pkg::clamp_q30(-34'($signed(d.y[l])));
				end else begin
					cos_s1[l] <= eavr_pkg::clamp_q30(34'($signed(d.x[l])));
					sin_s1[l] <= eavr_pkg::clamp_q30(34'($signed(d.y[l])));
				end
			end
			vec_s1 <= d.vec;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cpsi_cth_s2  <= eavr_pkg::mulq(cos_s1[Y], cos_s1[P]);
			cth_spsi_s2  <= eavr_pkg::mulq(cos_s1[P], sin_s1[Y]);
			cpsi_sphi_s2 <= eavr_pkg::mulq(cos_s1[Y], sin_s1[R]);
			cphi_spsi_s2 <= eavr_pkg::mulq(cos_s1[R], sin_s1[Y]);
			cphi_cpsi_s2 <= eavr_pkg::mulq(cos_s1[R], cos_s1[Y]);
			sphi_spsi_s2 <= eavr_pkg::mulq(sin_s1[R], sin_s1[Y]);
			cth_sphi_s2  <= eavr_pkg::mulq(cos_s1[P], sin_s1[R]);
			cth_cphi_s2  <= eavr_pkg::mulq(cos_s1[P], cos_s1[R]);
			sth_s2       <= sin_s1[P];
			vec_s2       <= vec_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t10_s3       <= eavr_pkg::mulq(cpsi_sphi_s2, sth_s2);
			t11_s3       <= eavr_pkg::mulq(sphi_spsi_s2, sth_s2);
			t20_s3       <= eavr_pkg::mulq(cphi_cpsi_s2, sth_s2);
			t21_s3       <= eavr_pkg::mulq(cphi_spsi_s2, sth_s2);
			cpsi_cth_s3  <= cpsi_cth_s2;
			cth_spsi_s3  <= cth_spsi_s2;
			cpsi_sphi_s3 <= cpsi_sphi_s2;
			cphi_spsi_s3 <= cphi_spsi_s2;
			cphi_cpsi_s3 <= cphi_cpsi_s2;
			sphi_spsi_s3 <= sphi_spsi_s2;
			cth_sphi_s3  <= cth_sphi_s2;
			cth_cphi_s3  <= cth_cphi_s2;
			sth_s3       <= sth_s2;
			vec_s3       <= vec_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q.r[0][0] <= cpsi_cth_s3;
			q.r[0][1] <= cth_spsi_s3;
			q.r[0][2] <= -sth_s3;
			q.r[1][0] <= eavr_pkg::clamp_q30(34'($signed(t10_s3)) - 34'($signed(cphi_spsi_s3)));
			q.r[1][1] <= eavr_pkg::clamp_q30(34'($signed(cphi_cpsi_s3)) + 34'($signed(t11_s3)));
			q.r[1][2] <= cth_sphi_s3;
			q.r[2][0] <= eavr_pkg::clamp_q30(34'($signed(sphi_spsi_s3)) + 34'($signed(t20_s3)));
			q.r[2][1] <= eavr_pkg::clamp_q30(34'($signed(t21_s3)) - 34'($signed(cpsi_sphi_s3)));
			q.r[2][2] <= cth_cphi_s3;
			q.vec     <= vec_s3;
		end
	end

endmodule

// File: test/eavr_rotation_checker.sv
// ----------------------------------------------------------------------------
// eavr_rotation_checker
// Predicts the body frame vector for every accepted request beat and compares
// it field by field with the response beats, in order.
// ----------------------------------------------------------------------------
module eavr_rotation_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  eavr_pkg::req_t req_data,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  eavr_pkg::rsp_t rsp_data,
	output int             fail_count,
	output int             pending
);

	localparam longint OneQ30  = 64'sd1073741824;
	localparam longint HalfQ30 = 64'sd536870912;

	eavr_pkg::rsp_t body_vec_q[$];

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic longint rmul(input longint a, input longint b);
		return (a * b + HalfQ30) >>> 30;
	endfunction

	// rotation-mode cordic with a single pi fold
	function automatic void angle_sincos(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint z, x, y, nx, ny;
		longint atn [18];
		bit flip;
		atn = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096,
			2048, 1024, 512, 256, 128, 64, 32, 16, 8};
		z = longint'(ang) * 128;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 1647099) begin
			z -= 3294199;
			flip = 1;
		end else if (z < -1647099) begin
			z += 3294199;
			flip = 1;
		end
		for (int i = 0; i < 18; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atn[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atn[i];
			end
			x = nx;
			y = ny;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clip(x, -OneQ30, OneQ30);
		s = clip(y, -OneQ30, OneQ30);
	endfunction

	function automatic eavr_pkg::rsp_t rotate_to_body(input eavr_pkg::req_t r);
		longint sphi, cphi, sth, cth, spsi, cpsi, acc;
		longint m [3][3];
		longint v [3];
		logic signed [31:0] o [3];
		eavr_pkg::rsp_t res;
		angle_sincos(r.roll, sphi, cphi);
		angle_sincos(r.pitch, sth, cth);
		angle_sincos(r.yaw, spsi, cpsi);
		v[0] = r.vec_x_in;
		v[1] = r.vec_y_in;
		v[2] = r.vec_z_in;
		m[0][0] = rmul(cpsi, cth);
		m[0][1] = rmul(cth, spsi);
		m[0][2] = -sth;
		m[1][0] = rmul(rmul(cpsi, sphi), sth) - rmul(cphi, spsi);
		m[1][1] = rmul(cphi, cpsi) + rmul(rmul(sphi, spsi), sth);
		m[1][2] = rmul(cth, sphi);
		m[2][0] = rmul(sphi, spsi) + rmul(rmul(cphi, cpsi), sth);
		m[2][1] = rmul(rmul(cphi, spsi), sth) - rmul(cpsi, sphi);
		m[2][2] = rmul(cth, cphi);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				acc += clip(m[i][j], -OneQ30, OneQ30) * v[j];
			end
			acc = (acc + HalfQ30) >>> 30;
			o[i] = 32'(clip(acc, -64'sd2147483648, 64'sd2147483647));
		end
		res.vec_x_out = o[0];
		res.vec_y_out = o[1];
		res.vec_z_out = o[2];
		return res;
	endfunction

	assign pending = body_vec_q.size();

	initial begin
		fail_count = 0;
	end

	always @(posedge clk) begin
		eavr_pkg::rsp_t want;
		if (arst_n && req_valid && !req_stall) begin
			body_vec_q.push_back(rotate_to_body(req_data));
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (body_vec_q.size() == 0) begin
				$error("response beat with nothing expected");
				fail_count++;
			end else begin
				want = body_vec_q.pop_front();
				if (want.vec_x_out !== rsp_data.vec_x_out) begin
					$error("vec_x_out expected %0d actual %0d", want.vec_x_out,
						rsp_data.vec_x_out);
					fail_count++;
				end
				if (want.vec_y_out !== rsp_data.vec_y_out) begin
					$error("vec_y_out expected %0d actual %0d", want.vec_y_out,
						rsp_data.vec_y_out);
					fail_count++;
				end
				if (want.vec_z_out !== rsp_data.vec_z_out) begin
					$error("vec_z_out expected %0d actual %0d", want.vec_z_out,
						rsp_data.vec_z_out);
					fail_count++;
				end
			end
		end
	end
endmodule

// File: test/euler_angle_vector_rotation_top_tb.sv
// ----------------------------------------------------------------------------
// euler_angle_vector_rotation_top_tb
// Directed corner angles and vectors, then random beats with random gaps and
// response stalls; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module euler_angle_vector_rotation_top_tb;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	eavr_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	eavr_pkg::rsp_t rsp_data;
	int fail_count;
	int pending;
	int cycle_count = 0;
	int rsp_wait = 0;

	always #2 clk = ~clk;

	euler_angle_vector_rotation_top uut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	eavr_rotation_checker chk (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.rsp_data(rsp_data), .fail_count(fail_count), .pending(pending)
	);

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 16'(32'sd12867 + $signed($urandom_range(0, 8)) - 4);
			1: return 16'(-32'sd12867 + $signed($urandom_range(0, 8)) - 4);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_vec();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	// valid stays up across back to back beats
	task automatic send_beat(input eavr_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			req_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// receiver stalls: a fresh wait per beat, with quiet stretches
	always @(posedge clk) begin
		int w;
		if (rsp_stall) begin
			if (rsp_wait <= 1) begin
				rsp_stall <= 0;
			end
			rsp_wait <= rsp_wait - 1;
		end else if (rsp_valid) begin
			w = (cycle_count / 2000) % 3 == 0 ? 0 : $urandom_range(0, 13);
			rsp_wait <= w;
			rsp_stall <= (w != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("euler_angle_vector_rotation_top_tb: errors");
			$finish;
		end
	end

	initial begin
		eavr_pkg::req_t r;
		logic [15:0] corner_ang [8];
		corner_ang = '{16'h0000, 16'h7fff, 16'h8000, 16'd12867, -16'sd12867,
			16'd12868, -16'sd12868, 16'd6434};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 20; i++) begin
			r.roll = corner_ang[i % 8];
			r.pitch = corner_ang[(i + 3) % 8];
			r.yaw = corner_ang[(i * 5) % 8];
			r.vec_x_in = i[0] ? 32'h7fffffff : 32'h80000000;
			r.vec_y_in = i[1] ? 32'h80000000 : 32'h00010000;
			r.vec_z_in = i[2] ? 32'h7fffffff : 32'hffffffff;
			send_beat(r);
		end
		for (int i = 0; i < 950; i++) begin
			r.roll = pick_angle();
			r.pitch = pick_angle();
			r.yaw = pick_angle();
			r.vec_x_in = pick_vec();
			r.vec_y_in = pick_vec();
			r.vec_z_in = pick_vec();
			send_beat(r);
		end
		req_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("euler_angle_vector_rotation_top_tb: clean");
		end else begin
			$display("euler_angle_vector_rotation_top_tb: errors");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+hdl
hdl/eavr_pkg.sv
hdl/eavr_cordic_cell.sv
hdl/eavr_matrix.sv
hdl/euler_angle_vector_rotation_top.sv
test/eavr_rotation_checker.sv
test/euler_angle_vector_rotation_top_tb.sv
